// ===== hdl/dltq_pkg.sv =====
`default_nettype none
package dltq_pkg;
  localparam int unsigned NumTimers = 16;
  localparam int unsigned SlotW = $clog2(NumTimers);
  localparam int unsigned CntW = $clog2(NumTimers + 1);
  localparam int unsigned TimeW = 24;
  localparam int unsigned DueW = 25;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EXPIRED = 2'd1,
    ST_ERROR   = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_INSERT,
    FSM_REMOVE,
    FSM_EXPIRE,
    FSM_RELINK,
    FSM_EMIT
  } fsm_e;

  // One list entry as it travels along the chain.
  typedef struct packed {
    logic             vld;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] delta;
    logic             periodic;
    logic [TimeW-1:0] period;
  } entry_t;

  // Per-cycle operation broadcast to every cell.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             pop;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] dur;
    logic             periodic;
    logic [TimeW-1:0] period;
    logic             sub_head;
    logic [TimeW-1:0] sub_val;
  } op_t;
endpackage
`default_nettype wire

// ===== hdl/dltq_if.sv =====
`default_nettype none
interface dltq_in_if;
  import dltq_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [3:0]       slot;
  logic             periodic;
  logic [23:0]      duration;
  logic [23:0]      elapsed;
  modport source (output valid, cmd, slot, periodic, duration, elapsed, input ready);
  modport sink (input valid, cmd, slot, periodic, duration, elapsed, output ready);
endinterface

interface dltq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         expired_slot;
  logic signed [24:0] first_due;
  logic               last;
  modport source (output valid, status, expired_slot, first_due, last, input ready);
  modport sink (input valid, status, expired_slot, first_due, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/dltq_cell.sv =====
`default_nettype none
// One list position. The list is kept packed from position 0 (head) with
// absolute due times. Each cell decides from its own entry and its
// left neighbor's entry whether to keep, shift right (insert) or take the
// right neighbor (removal).
module dltq_cell
  import dltq_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire op_t    op_i,
  input  wire entry_t left_i,
  input  wire logic   left_before_i,
  input  wire entry_t right_i,
  input  wire logic   is_head_i,
  output entry_t      entry_o,
  output logic        before_o,
  output logic        gone_o
);
  entry_t ent_q, ent_d;
  entry_t new_e;

  // Entries with due time at or below the new one stay ahead of it.
  assign before_o = ent_q.vld && (ent_q.delta <= op_i.dur);
  // This entry or one ahead of it is leaving the list.
  assign gone_o = (ent_q.vld && ent_q.slot == op_i.slot) || left_before_i;
  assign entry_o = ent_q;

  always_comb begin
    new_e.vld      = 1'b1;
    new_e.slot     = op_i.slot;
    new_e.delta    = op_i.dur;
    new_e.periodic = op_i.periodic;
    new_e.period   = op_i.period;
    ent_d = ent_q;
    if (op_i.ins) begin
      if (!before_o) begin
        ent_d = (is_head_i || left_before_i) ? new_e : left_i;
      end
    end else if (op_i.rem) begin
      if (gone_o) ent_d = right_i;
    end else if (op_i.pop) begin
      ent_d = right_i;
    end else if (op_i.sub_head && ent_q.vld) begin
      ent_d.delta = ent_q.delta - op_i.sub_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/delta_list_timer_queue_unit.sv =====
`default_nettype none
// Timer queue as a chain of NumTimers list cells holding absolute due times.
// An add or remove passes its insert or remove state, then the emit state; an
// error goes straight to emit. A tick pops each expired head entry, ages the
// rest, re-adds the periodic ones, then gives one result per cycle while taken.
// One request is in work at a time; the next is taken once the last result leaves.
// Reset empties the list and marks all slots idle.
module delta_list_timer_queue_unit
  import dltq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dltq_in_if.sink   in_i,
  dltq_out_if.source out_o
);
  fsm_e state_q, state_d;
  op_t  op;
  entry_t             ent   [NumTimers];
  logic [NumTimers-1:0] bef, gone;
  entry_t             nil_e;

  logic [NumTimers-1:0] active_q, active_d;
  logic [TimeW-1:0]     rem_q, rem_d;
  logic [SlotW-1:0]     done_q [NumTimers];
  logic [NumTimers-1:0] done_per_q;
  logic [TimeW-1:0]     done_prd_q [NumTimers];
  logic [CntW-1:0]      n_q, n_d, i_q, i_d;
  logic [SlotW-1:0]     slot_q;
  logic                 per_q;
  logic [TimeW-1:0]     dur_q;
  logic [1:0]           st_q, st_d;
  logic                 ov_q, ov_d;
  logic                 o_last_q, o_last_d;
  logic [1:0]           o_st_q, o_st_d;
  logic [SlotW-1:0]     o_slot_q, o_slot_d;
  logic                 push, tgt_act;
  logic [SlotW-1:0]     cur_slot;

  assign nil_e = '0;
  assign tgt_act = active_q[in_i.slot];
  assign in_i.ready = (state_q == FSM_IDLE) && !ov_q;
  assign cur_slot = done_q[i_q[SlotW-1:0]];

  // Chain of list cells.
  for (genvar g = 0; g < NumTimers; g++) begin : g_cell
    dltq_cell u_cell (
      .clk_i, .rst_ni, .op_i(op),
      .left_i       (g == 0 ? nil_e : ent[(g == 0) ? 0 : g-1]),
      .left_before_i(g == 0 ? 1'b0 : (op.rem ? gone[(g == 0) ? 0 : g-1]
                                             : bef[(g == 0) ? 0 : g-1])),
      .right_i      (g == NumTimers-1 ? nil_e : ent[(g == NumTimers-1) ? g : g+1]),
      .is_head_i    (g == 0),
      .entry_o      (ent[g]),
      .before_o     (bef[g]),
      .gone_o       (gone[g])
    );
  end

  // Control sequencer: next state and chain operations.
  always_comb begin
    state_d = state_q; op = '0; active_d = active_q; rem_d = rem_q;
    n_d = n_q; i_d = i_q; st_d = st_q; push = 1'b0;
    o_st_d = o_st_q; o_slot_d = o_slot_q; o_last_d = o_last_q;
    op.slot = slot_q; op.dur = dur_q; op.periodic = per_q; op.period = dur_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          n_d = '0; i_d = '0; rem_d = in_i.elapsed;
          unique case (cmd_e'(in_i.cmd))
            CMD_ADD:    if (tgt_act) begin st_d = ST_ERROR; state_d = FSM_EMIT; end
                        else begin st_d = ST_DONE; state_d = FSM_INSERT;
                          active_d[in_i.slot] = 1'b1; end
            CMD_REMOVE: if (!tgt_act) begin st_d = ST_ERROR; state_d = FSM_EMIT; end
                        else begin st_d = ST_DONE; state_d = FSM_REMOVE;
                          active_d[in_i.slot] = 1'b0; end
            CMD_TICK:   begin st_d = ST_DONE; state_d = FSM_EXPIRE; end
            default:    begin st_d = ST_ERROR; state_d = FSM_EMIT; end
          endcase
        end
      end
      FSM_INSERT: begin op.ins = 1'b1; state_d = FSM_EMIT; end
      FSM_REMOVE: begin op.rem = 1'b1; state_d = FSM_EMIT; end
      FSM_EXPIRE: begin
        // Pop head entries due within the elapsed time, then age the rest.
        if (ent[0].vld && ent[0].delta <= rem_q) begin
          op.pop = 1'b1; n_d = n_q + 1'b1;
        end else begin
          op.sub_head = 1'b1; op.sub_val = rem_q; state_d = FSM_RELINK;
        end
      end
      FSM_RELINK: begin
        if (i_q == n_q) begin
          i_d = '0; state_d = FSM_EMIT;
        end else begin
          i_d = i_q + 1'b1;
          op.slot = cur_slot; op.dur = done_prd_q[i_q[SlotW-1:0]];
          op.period = op.dur; op.periodic = done_per_q[i_q[SlotW-1:0]];
          if (op.periodic) op.ins = 1'b1;
          else active_d[cur_slot] = 1'b0;
        end
      end
      FSM_EMIT: begin
        if (!ov_q || out_o.ready) begin
          push = 1'b1;
          if (n_q == '0) begin
            o_st_d = st_q; o_slot_d = '0; o_last_d = 1'b1; state_d = FSM_IDLE;
          end else begin
            o_st_d = ST_EXPIRED; o_slot_d = cur_slot;
            o_last_d = (i_q + 1'b1 == n_q); i_d = i_q + 1'b1;
            if (i_q + 1'b1 == n_q) state_d = FSM_IDLE;
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
    ov_d = push | (ov_q & !out_o.ready);
  end

  // Relative stages of the chain operations use absolute values: relink
  // durations are compared against entries already aged by the tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE; active_q <= '0; ov_q <= 1'b0;
      n_q <= '0; i_q <= '0;
    end else begin
      state_q <= state_d; active_q <= active_d; ov_q <= ov_d;
      n_q <= n_d; i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; st_q <= st_d;
    if (push) begin
      o_st_q <= o_st_d; o_slot_q <= o_slot_d; o_last_q <= o_last_d;
    end
    if (state_q == FSM_IDLE) begin
      slot_q <= in_i.slot; per_q <= in_i.periodic; dur_q <= in_i.duration;
    end
    if (op.pop) begin
      done_q[n_q[SlotW-1:0]]     <= ent[0].slot;
      done_per_q[n_q[SlotW-1:0]] <= ent[0].periodic;
      done_prd_q[n_q[SlotW-1:0]] <= ent[0].period;
    end
  end

  // The head delay is read from the chain when the result is taken.
  assign out_o.valid        = ov_q;
  assign out_o.status       = o_st_q;
  assign out_o.expired_slot = o_slot_q;
  assign out_o.last         = o_last_q;
  assign out_o.first_due    = ent[0].vld ? $signed({1'b0, ent[0].delta}) : -25'sd1;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q == FSM_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_o.ready |=> ov_q) else $error("result dropped");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(NumTimers)) else $error("expiry count overflow");
endmodule
`default_nettype wire
